>>> rtl/char_lcd_frame_buffer_refresh_core_assert.svh
// Assertion macros for the character LCD frame buffer core.
// Used by the checker; expects i_clk and i_rst_n in the calling scope.
`ifndef CHAR_LCD_FRAME_BUFFER_REFRESH_CORE_ASSERT_SVH
`define CHAR_LCD_FRAME_BUFFER_REFRESH_CORE_ASSERT_SVH

// Checked only while out of reset.
`define CLFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define CLFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/clfb_pkg.sv
// Shared types and constants of the character LCD frame buffer core.
// No dependencies.
package clfb_pkg;

    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_NEWLINE = 3'd1,
        ACT_SETPOS  = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_REFRESH = 3'd4
    } t_action;

    localparam int         CFG_IDX_W   = 1;
    localparam int         CFG_DATA_W  = 6;
    localparam logic [0:0] CFG_COLUMNS = 1'b0;
    localparam logic [0:0] CFG_ROWS    = 1'b1;

    localparam int         ROWS_W      = 3;
    localparam logic [5:0] COLS_RESET  = 6'd16;
    localparam logic [2:0] ROWS_RESET  = 3'd2;
    localparam logic [2:0] ROWS_MAX    = 3'd4;

    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0] CMD_LINE1_OFS = 8'h40;

    // output queue
    localparam int OUT_DEPTH = 4;
    localparam int PTRW      = $clog2(OUT_DEPTH);
    localparam int CNTW      = PTRW + 1;

    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_byte;
        logic       last_of_run;
    } t_out_word;

    typedef struct packed {
        logic       wr;
        logic       nl;
        logic       setp;
        logic [5:0] column;
        logic [1:0] row;
    } t_cur_cmd;

endpackage

>>> rtl/clfb_in_if.sv
// Input channel of the character LCD frame buffer core: one action word.
// No dependencies.
interface clfb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] char_code;
    logic [5:0] column;
    logic [1:0] row;
    logic       panel_line;

    modport source (output valid, action, char_code, column, row, panel_line, input ready);
    modport sink   (input valid, action, char_code, column, row, panel_line, output ready);
endinterface

>>> rtl/clfb_out_if.sv
// Output channel of the character LCD frame buffer core: one bus byte word.
// No dependencies.
interface clfb_out_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [7:0] bus_byte;
    logic       last_of_run;

    modport source (output valid, register_select, bus_byte, last_of_run, input ready);
    modport sink   (input valid, register_select, bus_byte, last_of_run, output ready);
endinterface

>>> rtl/clfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

>>> rtl/clfb_store.sv
// Character store: buffer RAM plus per-cell valid flags; unwritten cells read as space.
// Depends on clfb_pkg and clfb_ram.
module clfb_store #(
    parameter int MAX_CELLS = 80
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [$clog2(MAX_CELLS)-1:0] i_waddr,
    input  logic [7:0]                   i_wdata,
    input  logic                         i_clear,
    input  logic                         i_re,
    input  logic [$clog2(MAX_CELLS)-1:0] i_raddr,
    input  logic                         i_blank,
    output logic [7:0]                   o_rdata
);
    import clfb_pkg::*;

    logic [MAX_CELLS-1:0] r_valid;
    logic                 r_rd_valid;
    logic [7:0]           ram_q;

    clfb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    // clear empties every cell at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_valid <= !i_blank && r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? ram_q : CHAR_SPACE;
endmodule

>>> rtl/clfb_cursor.sv
// Write cursor: advance on write, set position, and newline through a bit-serial
// remainder unit. Depends on clfb_pkg.
module clfb_cursor #(
    parameter int MAX_CELLS   = 80,
    parameter int MAX_COLUMNS = 40
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  clfb_pkg::t_cur_cmd                   i_cmd,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]     i_cols,
    input  logic [$clog2(MAX_CELLS+1)-1:0]       i_cap,
    output logic                                 o_busy,
    output logic                                 o_wr_en,
    output logic [$clog2(MAX_CELLS)-1:0]         o_wr_addr
);
    import clfb_pkg::*;

    localparam int CW    = $clog2(MAX_CELLS + 1);
    localparam int AW    = $clog2(MAX_CELLS);
    localparam int COLW  = $clog2(MAX_COLUMNS + 1);
    localparam int RMW   = COLW + 1;
    localparam int SPW   = (COLW + 3 > CW) ? COLW + 3 : CW;
    localparam int NPW   = ((CW > COLW) ? CW : COLW) + 1;
    localparam int STEPW = $clog2(CW + 1);

    typedef enum logic [2:0] {
        CS_IDLE = 3'b001,
        CS_DIV  = 3'b010,
        CS_FIX  = 3'b100
    } t_cur_state;

    t_cur_state       r_state, n_state;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic [CW-1:0]    r_div, n_div;
    logic [COLW-1:0]  r_rem, n_rem;
    logic [STEPW-1:0] r_cnt, n_cnt;

    logic [RMW-1:0]   trial;
    logic [SPW-1:0]   set_pos;
    logic [NPW-1:0]   nl_pos;
    logic             wr_ok;

    assign wr_ok   = r_cursor < i_cap;
    assign set_pos = SPW'(i_cmd.column) + SPW'(i_cmd.row) * SPW'(i_cols);
    // one restoring step: remainder stays below cols
    assign trial   = {r_rem, r_div[CW-1]};
    // next row start = cursor - (cursor mod cols) + cols
    assign nl_pos  = NPW'(r_cursor) - NPW'(r_rem) + NPW'(i_cols);

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_div    = r_div;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        case (r_state)
            CS_IDLE: begin
                if (i_cmd.wr) begin
                    if (wr_ok) begin
                        n_cursor = r_cursor + CW'(1);
                    end
                end else if (i_cmd.setp) begin
                    n_cursor = (set_pos > SPW'(i_cap)) ? i_cap : CW'(set_pos);
                end else if (i_cmd.nl) begin
                    n_state = CS_DIV;
                    n_div   = r_cursor;
                    n_rem   = '0;
                    n_cnt   = STEPW'(CW);
                end
            end
            CS_DIV: begin
                n_div = r_div << 1;
                n_rem = (trial >= RMW'(i_cols)) ? COLW'(trial - RMW'(i_cols)) : COLW'(trial);
                n_cnt = r_cnt - STEPW'(1);
                if (r_cnt == STEPW'(1)) begin
                    n_state = CS_FIX;
                end
            end
            CS_FIX: begin
                n_cursor = (nl_pos > NPW'(i_cap)) ? i_cap : CW'(nl_pos);
                n_state  = CS_IDLE;
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= CS_IDLE;
            r_cursor <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_busy    = r_state != CS_IDLE;
    assign o_wr_en   = i_cmd.wr && wr_ok && (r_state == CS_IDLE);
    assign o_wr_addr = r_cursor[AW-1:0];
endmodule

>>> rtl/clfb_out_fifo.sv
// Output word queue between the refresh sequencer and the output channel.
// Depends on clfb_pkg.
module clfb_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clfb_pkg::t_out_word i_word,
    input  logic                i_pop,
    output logic                o_valid,
    output clfb_pkg::t_out_word o_word,
    output logic                o_room1,
    output logic                o_room2
);
    import clfb_pkg::*;

    t_out_word       r_mem [OUT_DEPTH];
    logic [PTRW-1:0] r_wr, r_rd;
    logic [CNTW-1:0] r_cnt, n_cnt;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNTW'(1);
            2'b01:   n_cnt = r_cnt - CNTW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTRW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTRW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_word  = r_mem[r_rd];
    assign o_room1 = r_cnt < CNTW'(OUT_DEPTH);
    assign o_room2 = r_cnt < CNTW'(OUT_DEPTH - 1);
endmodule

>>> rtl/clfb_refresh.sv
// Refresh sequencer: emits the set-address command, then walks the cells of
// one or two rows through the store read port. Depends on clfb_pkg.
module clfb_refresh #(
    parameter int MAX_CELLS   = 80,
    parameter int MAX_COLUMNS = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_line,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]  i_cols,
    input  logic [clfb_pkg::ROWS_W-1:0]       i_rows,
    input  logic [$clog2(MAX_CELLS+1)-1:0]    i_cap,
    input  logic                              i_room1,
    input  logic                              i_room2,
    input  logic [7:0]                        i_rdata,
    output logic                              o_busy,
    output logic                              o_rd_en,
    output logic [$clog2(MAX_CELLS)-1:0]      o_rd_addr,
    output logic                              o_rd_blank,
    output logic                              o_push,
    output clfb_pkg::t_out_word               o_word
);
    import clfb_pkg::*;

    localparam int CW   = $clog2(MAX_CELLS + 1);
    localparam int AW   = $clog2(MAX_CELLS);
    localparam int COLW = $clog2(MAX_COLUMNS + 1);
    localparam int GW   = COLW + 2;
    localparam int AXW  = (GW > CW) ? GW : CW;

    typedef enum logic [3:0] {
        RS_IDLE = 4'b0001,
        RS_CMD  = 4'b0010,
        RS_ROW1 = 4'b0100,
        RS_ROW2 = 4'b1000
    } t_ref_state;

    t_ref_state      r_state;
    logic            r_line;
    logic [GW-1:0]   r_addr;
    logic [COLW-1:0] r_left;
    logic [COLW-1:0] r_len2;
    logic            r_has2;

    logic            r_s1_valid;
    logic            r_s1_cmd;
    logic [7:0]      r_s1_byte;
    logic            r_s1_last;

    logic            issue;
    logic            row_end;
    logic [AXW-1:0]  addr_x;
    logic [COLW-1:0] len2;

    // second row carries what is left of the run's column budget
    assign len2    = (i_cols > COLW'(MAX_COLUMNS) - i_cols) ? COLW'(MAX_COLUMNS) - i_cols : i_cols;
    assign issue   = (r_state != RS_IDLE) && (r_s1_valid ? i_room2 : i_room1);
    assign row_end = r_left == COLW'(1);
    assign addr_x  = AXW'(r_addr);

    assign o_rd_blank = addr_x >= AXW'(i_cap);
    assign o_rd_addr  = addr_x[AW-1:0];
    assign o_rd_en    = issue && ((r_state == RS_ROW1) || (r_state == RS_ROW2));
    assign o_busy     = r_state != RS_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= RS_IDLE;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            case (r_state)
                RS_IDLE: begin
                    if (i_start) begin
                        r_state <= RS_CMD;
                    end
                end
                RS_CMD: begin
                    if (issue) begin
                        r_state <= RS_ROW1;
                    end
                end
                RS_ROW1: begin
                    if (issue && row_end) begin
                        r_state <= r_has2 ? RS_ROW2 : RS_IDLE;
                    end
                end
                RS_ROW2: begin
                    if (issue && row_end) begin
                        r_state <= RS_IDLE;
                    end
                end
                default: begin
                    r_state <= RS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == RS_IDLE) begin
            if (i_start) begin
                r_line <= i_line;
                r_addr <= i_line ? GW'(i_cols) : '0;
                r_left <= i_cols;
                r_len2 <= len2;
                r_has2 <= (i_rows >= (i_line ? ROWS_MAX : ROWS_MAX - 3'd1)) && (len2 != '0);
            end
        end else if (issue && (r_state != RS_CMD)) begin
            if (row_end) begin
                // jump over the interleaved row to the second row of the line
                r_addr <= r_addr + GW'(1) + GW'(i_cols);
                r_left <= r_len2;
            end else begin
                r_addr <= r_addr + GW'(1);
                r_left <= r_left - COLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_cmd  <= r_state == RS_CMD;
            r_s1_byte <= CMD_SET_ADDR | (r_line ? CMD_LINE1_OFS : 8'h00);
            r_s1_last <= row_end && ((r_state == RS_ROW2) || ((r_state == RS_ROW1) && !r_has2));
        end
    end

    assign o_push                 = r_s1_valid;
    assign o_word.register_select = !r_s1_cmd;
    assign o_word.bus_byte        = r_s1_cmd ? r_s1_byte : i_rdata;
    assign o_word.last_of_run     = r_s1_last;
endmodule

>>> rtl/char_lcd_frame_buffer_refresh_core.sv
// Character LCD frame buffer core, top level.
// Depends on clfb_pkg, clfb_in_if, clfb_out_if, clfb_store, clfb_cursor,
// clfb_out_fifo and clfb_refresh.
//
//  channel   dir  handshake          word
//  i_cmd     in   valid/ready        action, char_code, column, row, panel_line
//  o_bus     out  valid/ready        register_select, bus_byte, last_of_run
//  cfg       in   i_cfg_we           i_cfg_index, i_cfg_data
//
// Write, set position and clear leave the input channel ready for the next word.
// Newline runs through the bit-serial remainder unit in the cursor, divide steps
// then a fix-up state, and holds the input channel busy until it is done.
// Refresh emits the set-address command and then its data bytes, one store read per
// cycle while the output queue has room; a stalled output holds up to four words.
// On reset, per-cell valid flags make the whole store read as spaces.
module char_lcd_frame_buffer_refresh_core #(
    parameter int MAX_CELLS   = 80,
    parameter int MAX_COLUMNS = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clfb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clfb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    clfb_in_if.sink                           i_cmd,
    clfb_out_if.source                        o_bus
);
    import clfb_pkg::*;

    localparam int CW   = $clog2(MAX_CELLS + 1);
    localparam int AW   = $clog2(MAX_CELLS);
    localparam int COLW = $clog2(MAX_COLUMNS + 1);
    localparam int GW   = COLW + 2;
    localparam int PW   = (GW > CW) ? GW : CW;

    logic [CFG_DATA_W-1:0] r_cfg_cols;
    logic [ROWS_W-1:0]     r_cfg_rows;

    logic [COLW-1:0]   eff_cols;
    logic [ROWS_W-1:0] eff_rows;
    logic [PW-1:0]     prod;
    logic [CW-1:0]     cap;

    logic      accept;
    t_cur_cmd  cur_cmd;
    logic      cur_busy;
    logic      wr_en;
    logic [AW-1:0] wr_addr;
    logic      clear;
    logic      ref_start;
    logic      ref_busy;
    logic      rd_en;
    logic [AW-1:0] rd_addr;
    logic      rd_blank;
    logic [7:0] rdata;
    logic      push;
    t_out_word push_word;
    t_out_word out_word;
    logic      out_valid;
    logic      room1;
    logic      room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= COLS_RESET;
            r_cfg_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_cfg_cols <= i_cfg_data;
                CFG_ROWS:    r_cfg_rows <= i_cfg_data[ROWS_W-1:0];
                default:     ;
            endcase
        end
    end

    // effective geometry
    always_comb begin
        if (r_cfg_cols == '0) begin
            eff_cols = COLW'(1);
        end else if (r_cfg_cols > CFG_DATA_W'(MAX_COLUMNS)) begin
            eff_cols = COLW'(MAX_COLUMNS);
        end else begin
            eff_cols = COLW'(r_cfg_cols);
        end
        if (r_cfg_rows == '0) begin
            eff_rows = ROWS_W'(1);
        end else if (r_cfg_rows > ROWS_MAX) begin
            eff_rows = ROWS_MAX;
        end else begin
            eff_rows = r_cfg_rows;
        end
    end

    assign prod = PW'(eff_cols) * PW'(eff_rows);
    assign cap  = (prod > PW'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(prod);

    assign i_cmd.ready = !cur_busy && !ref_busy;
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign cur_cmd.wr     = accept && (i_cmd.action == ACT_WRITE);
    assign cur_cmd.nl     = accept && (i_cmd.action == ACT_NEWLINE);
    assign cur_cmd.setp   = accept && (i_cmd.action == ACT_SETPOS);
    assign cur_cmd.column = i_cmd.column;
    assign cur_cmd.row    = i_cmd.row;

    assign clear     = accept && (i_cmd.action == ACT_CLEAR);
    // line 1 exists only on panels of two or more rows
    assign ref_start = accept && (i_cmd.action == ACT_REFRESH)
                       && !(i_cmd.panel_line && (eff_rows < ROWS_W'(2)));

    clfb_cursor #(
        .MAX_CELLS   (MAX_CELLS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cur_cmd),
        .i_cols    (eff_cols),
        .i_cap     (cap),
        .o_busy    (cur_busy),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr)
    );

    clfb_store #(
        .MAX_CELLS (MAX_CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_cmd.char_code),
        .i_clear (clear),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .i_blank (rd_blank),
        .o_rdata (rdata)
    );

    clfb_refresh #(
        .MAX_CELLS   (MAX_CELLS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_refresh (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ref_start),
        .i_line     (i_cmd.panel_line),
        .i_cols     (eff_cols),
        .i_rows     (eff_rows),
        .i_cap      (cap),
        .i_room1    (room1),
        .i_room2    (room2),
        .i_rdata    (rdata),
        .o_busy     (ref_busy),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_rd_blank (rd_blank),
        .o_push     (push),
        .o_word     (push_word)
    );

    clfb_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (out_valid && o_bus.ready),
        .o_valid (out_valid),
        .o_word  (out_word),
        .o_room1 (room1),
        .o_room2 (room2)
    );

    assign o_bus.valid           = out_valid;
    assign o_bus.register_select = out_word.register_select;
    assign o_bus.bus_byte        = out_word.bus_byte;
    assign o_bus.last_of_run     = out_word.last_of_run;
endmodule

>>> rtl/clfb_checker.sv
// Port-level checker for the character LCD frame buffer core, bound to the top.
// Depends on clfb_pkg and char_lcd_frame_buffer_refresh_core_assert.svh.
`include "char_lcd_frame_buffer_refresh_core_assert.svh"

module clfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_register_select,
    input logic [7:0] i_bus_byte,
    input logic       i_last_of_run
);
    import clfb_pkg::*;

    logic r_in_run;

    // set by a taken command word, cleared by a taken last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            if (i_last_of_run) begin
                r_in_run <= 1'b0;
            end else if (!i_register_select) begin
                r_in_run <= 1'b1;
            end
        end
    end

    `CLFB_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bus_byte) && $stable(i_register_select) && $stable(i_last_of_run), "output word changed while stalled")
    `CLFB_ASSERT(a_cmd_form, i_out_valid && !i_register_select |-> !i_last_of_run && (i_bus_byte == CMD_SET_ADDR || i_bus_byte == (CMD_SET_ADDR | CMD_LINE1_OFS)), "bad command word")
    `CLFB_ASSERT(a_run_order, i_out_valid |-> (i_register_select == r_in_run), "run not opened by a command or data outside a run")
    `CLFB_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_out_valid, "output valid right after reset")
endmodule

bind char_lcd_frame_buffer_refresh_core clfb_checker u_clfb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_bus.valid),
    .i_out_ready       (o_bus.ready),
    .i_register_select (o_bus.register_select),
    .i_bus_byte        (o_bus.bus_byte),
    .i_last_of_run     (o_bus.last_of_run)
);

>>> tb/tb_char_lcd_frame_buffer_refresh_core.sv
// Testbench for char_lcd_frame_buffer_refresh_core: directed table plus random phases,
// each result checked against a frame-buffer predictor, with random stalls on both sides in most phases.
// Depends on clfb_pkg, clfb_in_if, clfb_out_if and the core RTL.
module tb_char_lcd_frame_buffer_refresh_core;
    import clfb_pkg::*;

    localparam int CELLS         = 80;
    localparam int COLS_LIMIT    = 40;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_WORDS   = 37;

    // action codes the block ignores
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0] action;
        logic [7:0] char_code;
        logic [5:0] column;
        logic [1:0] row;
        logic       panel_line;
    } t_cmd_word;

    typedef struct {
        bit         is_cfg;
        logic [5:0] cols;
        logic [2:0] rows;
        t_cmd_word  w;
        bit         typed;
        int         n_data;
        logic [7:0] fill;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    clfb_in_if  cmd_if ();
    clfb_out_if bus_if ();

    char_lcd_frame_buffer_refresh_core #(
        .MAX_CELLS   (CELLS),
        .MAX_COLUMNS (COLS_LIMIT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd_if),
        .o_bus       (bus_if)
    );

    logic [7:0]  frame_cells [CELLS];
    int unsigned cursor_cell;
    logic [5:0]  geo_cols;
    logic [2:0]  geo_rows;
    t_out_word   pending_bus_words [$];
    int          err_count;
    int          cycle_count;
    bit          tx_gaps_on;
    bit          rx_stalls_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_cols();
        int unsigned c = geo_cols;
        if (c == 0) c = 1;
        if (c > COLS_LIMIT) c = COLS_LIMIT;
        return c;
    endfunction

    function automatic int unsigned eff_rows();
        int unsigned r = geo_rows;
        if (r == 0) r = 1;
        if (r > ROWS_MAX) r = ROWS_MAX;
        return r;
    endfunction

    function automatic int unsigned capacity_cells();
        int unsigned n = eff_cols() * eff_rows();
        return (n > CELLS) ? CELLS : n;
    endfunction

    function automatic logic [7:0] cell_byte(int unsigned idx);
        if (idx >= capacity_cells() || idx >= CELLS) return CHAR_SPACE;
        return frame_cells[idx];
    endfunction

    function automatic void push_word(logic rs, logic [7:0] b);
        t_out_word o;
        o.register_select = rs;
        o.bus_byte        = b;
        o.last_of_run     = 1'b0;
        pending_bus_words.push_back(o);
    endfunction

    function automatic void mark_run_end();
        t_out_word o;
        o = pending_bus_words.pop_back();
        o.last_of_run = 1'b1;
        pending_bus_words.push_back(o);
    endfunction

    function automatic logic [7:0] addr_cmd(logic line);
        return line ? (CMD_SET_ADDR | CMD_LINE1_OFS) : CMD_SET_ADDR;
    endfunction

    // Applies one accepted word to the frame model; queues the bus words it causes.
    function automatic void advance_frame_model(t_cmd_word w, bit push);
        int unsigned cols;
        int unsigned rows;
        int unsigned cap;
        int unsigned p;
        int unsigned sent;
        int unsigned rr;
        cols = eff_cols();
        rows = eff_rows();
        cap  = capacity_cells();
        case (w.action)
            ACT_WRITE: begin
                if (cursor_cell < cap) begin
                    frame_cells[cursor_cell] = w.char_code;
                    cursor_cell++;
                end
            end
            ACT_NEWLINE: begin
                p = (cursor_cell / cols + 1) * cols;
                cursor_cell = (p > cap) ? cap : p;
            end
            ACT_SETPOS: begin
                p = int'(w.column) + int'(w.row) * cols;
                cursor_cell = (p > cap) ? cap : p;
            end
            ACT_CLEAR: begin
                foreach (frame_cells[i]) frame_cells[i] = CHAR_SPACE;
            end
            ACT_REFRESH: begin
                if (push && !(w.panel_line && rows < 2)) begin
                    push_word(1'b0, addr_cmd(w.panel_line));
                    sent = 0;
                    for (int r = 0; r < 2; r++) begin
                        rr = (r == 1) ? int'(w.panel_line) + 2 : int'(w.panel_line);
                        if (r == 1 && rows < rr + 1) break;
                        for (int unsigned i = 0; i < cols && sent < COLS_LIMIT; i++) begin
                            push_word(1'b1, cell_byte(rr * cols + i));
                            sent++;
                        end
                    end
                    mark_run_end();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void push_typed(t_step s);
        if (s.n_data == 0) return;
        push_word(1'b0, addr_cmd(s.w.panel_line));
        for (int i = 0; i < s.n_data; i++) push_word(1'b1, s.fill);
        mark_run_end();
    endfunction

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic logic [5:0] pick_cols();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return COLS_LIMIT;
            3:       return 6'h3F;
            default: return $urandom_range(1, COLS_LIMIT);
        endcase
    endfunction

    function automatic logic [2:0] pick_rows();
        case ($urandom_range(0, 9))
            0:       return 3'd0;
            1:       return $urandom_range(5, 7);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic t_cmd_word random_word();
        t_cmd_word w;
        int pick = $urandom_range(0, 99);
        w.char_code  = $urandom_range(0, 255);
        w.column     = ($urandom_range(0, 9) < 7) ? $urandom_range(0, eff_cols() - 1)
                                                  : $urandom_range(0, 63);
        w.row        = $urandom_range(0, 3);
        w.panel_line = $urandom_range(0, 1);
        if (pick < 45)      w.action = ACT_WRITE;
        else if (pick < 55) w.action = ACT_NEWLINE;
        else if (pick < 67) w.action = ACT_SETPOS;
        else if (pick < 70) w.action = ACT_CLEAR;
        else if (pick < 95) w.action = ACT_REFRESH;
        else                w.action = $urandom_range(ACT_SPARE_5, ACT_SPARE_7);
        return w;
    endfunction

    function automatic t_step cfg_row(logic [5:0] c, logic [2:0] r);
        t_step s;
        s.is_cfg = 1'b1;
        s.cols   = c;
        s.rows   = r;
        s.w      = '{ACT_WRITE, 8'h00, 6'd0, 2'd0, 1'b0};
        s.typed  = 1'b0;
        s.n_data = 0;
        s.fill   = CHAR_SPACE;
        return s;
    endfunction

    function automatic t_step act_row(logic [2:0] a, logic [7:0] ch, logic [5:0] col,
                                      logic [1:0] rw, logic ln);
        t_step s;
        s = cfg_row(6'd0, 3'd0);
        s.is_cfg = 1'b0;
        s.w      = '{a, ch, col, rw, ln};
        return s;
    endfunction

    // refresh whose whole run is known up front
    function automatic t_step typed_row(logic ln, int n, logic [7:0] fill);
        t_step s;
        s = act_row(ACT_REFRESH, 8'h00, 6'd0, 2'd0, ln);
        s.typed  = 1'b1;
        s.n_data = n;
        s.fill   = fill;
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 200) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_word(input t_cmd_word w);
        int gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.action     <= w.action;
        cmd_if.char_code  <= w.char_code;
        cmd_if.column     <= w.column;
        cmd_if.row        <= w.row;
        cmd_if.panel_line <= w.panel_line;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
    endtask

    task automatic write_geometry(input logic [5:0] c, input logic [2:0] r);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_COLUMNS;
        i_cfg_data  <= c;
        @(posedge i_clk);
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= {3'b000, r};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        geo_cols = c;
        geo_rows = r;
    endtask

    // newline may still be busy after the last word; settle covers it
    task automatic wait_results_done();
        int spins = 0;
        cmd_if.valid <= 1'b0;
        while (pending_bus_words.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // bus receiver: random stalls, compares every accepted word
    initial begin
        t_out_word want;
        int hold;
        bus_if.ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && bus_if.valid && bus_if.ready) begin
                if (pending_bus_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word rs=%0b byte=%02h last=%0b",
                        bus_if.register_select, bus_if.bus_byte, bus_if.last_of_run));
                end else begin
                    want = pending_bus_words.pop_front();
                    if (bus_if.register_select !== want.register_select)
                        report_mismatch($sformatf("register_select got %0b want %0b",
                            bus_if.register_select, want.register_select));
                    if (bus_if.bus_byte !== want.bus_byte)
                        report_mismatch($sformatf("bus_byte got %02h want %02h",
                            bus_if.bus_byte, want.bus_byte));
                    if (bus_if.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run got %0b want %0b",
                            bus_if.last_of_run, want.last_of_run));
                end
            end
            if (hold == 0 && rx_stalls_on && $urandom_range(0, 2) == 0) hold = pick_gap();
            if (hold > 0) begin
                hold--;
                bus_if.ready <= 1'b0;
            end else begin
                bus_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_char_lcd_frame_buffer_refresh_core failed");
        $finish;
    end

    initial begin
        t_step     dir_steps [$];
        t_cmd_word w;
        int        burst;
        int        sent_words;
        bit        paused;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_COLUMNS;
        i_cfg_data        <= '0;
        cmd_if.valid      <= 1'b0;
        cmd_if.action     <= ACT_WRITE;
        cmd_if.char_code  <= '0;
        cmd_if.column     <= '0;
        cmd_if.row        <= '0;
        cmd_if.panel_line <= 1'b0;
        err_count    = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        foreach (frame_cells[i]) frame_cells[i] = CHAR_SPACE;
        cursor_cell = 0;
        geo_cols    = COLS_RESET;
        geo_rows    = ROWS_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_steps = '{
            typed_row(1'b0, 16, CHAR_SPACE),                  // buffer reads blank after reset
            typed_row(1'b1, 16, CHAR_SPACE),
            act_row(ACT_WRITE,   8'h00, 6'd0,  2'd0, 1'b0),
            act_row(ACT_WRITE,   8'hFF, 6'd0,  2'd0, 1'b0),
            act_row(ACT_SETPOS,  8'h00, 6'h3F, 2'd3, 1'b1),   // clamps to capacity
            act_row(ACT_WRITE,   8'h41, 6'd0,  2'd0, 1'b0),   // dropped, buffer full
            act_row(ACT_NEWLINE, 8'h00, 6'd0,  2'd0, 1'b0),   // saturates
            act_row(ACT_REFRESH, 8'h00, 6'd0,  2'd0, 1'b0),
            act_row(ACT_SETPOS,  8'h00, 6'd15, 2'd0, 1'b0),
            act_row(ACT_WRITE,   8'h41, 6'd0,  2'd0, 1'b0),
            act_row(ACT_WRITE,   8'h42, 6'd0,  2'd0, 1'b0),   // wraps into row 1
            act_row(ACT_REFRESH, 8'h00, 6'd0,  2'd0, 1'b1),
            act_row(ACT_SPARE_5, 8'hAA, 6'd21, 2'd2, 1'b1),
            act_row(ACT_SPARE_7, 8'h55, 6'd42, 2'd1, 1'b0),
            act_row(ACT_CLEAR,   8'h00, 6'd0,  2'd0, 1'b0),
            typed_row(1'b0, 16, CHAR_SPACE),
            cfg_row(6'd40, 3'd4),
            act_row(ACT_SETPOS,  8'h00, 6'd39, 2'd1, 1'b0),   // last cell
            act_row(ACT_WRITE,   8'h7E, 6'd0,  2'd0, 1'b0),
            act_row(ACT_WRITE,   8'h55, 6'd0,  2'd0, 1'b0),   // dropped
            act_row(ACT_REFRESH, 8'h00, 6'd0,  2'd0, 1'b1),   // run capped at 40 bytes
            typed_row(1'b0, 40, CHAR_SPACE),
            cfg_row(6'd0, 3'd0),                              // zero geometry acts as 1x1
            typed_row(1'b1, 0, CHAR_SPACE),                   // line 1 absent on one row
            typed_row(1'b0, 1, CHAR_SPACE),
            act_row(ACT_SETPOS,  8'h00, 6'd0,  2'd0, 1'b0),
            act_row(ACT_WRITE,   8'h5A, 6'd0,  2'd0, 1'b0),
            act_row(ACT_NEWLINE, 8'h00, 6'd0,  2'd0, 1'b0),
            act_row(ACT_REFRESH, 8'h00, 6'd0,  2'd0, 1'b0),
            cfg_row(6'd21, 3'd4),                             // row 3 runs past the store
            act_row(ACT_REFRESH, 8'h00, 6'd0,  2'd0, 1'b1)
        };

        foreach (dir_steps[k]) begin
            if (dir_steps[k].is_cfg) begin
                wait_results_done();
                write_geometry(dir_steps[k].cols, dir_steps[k].rows);
            end else begin
                send_word(dir_steps[k].w);
                advance_frame_model(dir_steps[k].w, !dir_steps[k].typed);
                if (dir_steps[k].typed) push_typed(dir_steps[k]);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_results_done();
            write_geometry(pick_cols(), pick_rows());
            tx_gaps_on   = (ph == 1) || (ph != 0 && $urandom_range(0, 3) != 0);
            rx_stalls_on = (ph == 1) || (ph != 0 && $urandom_range(0, 3) != 0);
            sent_words = 0;
            paused     = 1'b0;
            while (sent_words < PHASE_WORDS) begin
                w = random_word();
                burst = 1;
                if (w.action == ACT_WRITE && $urandom_range(0, 3) == 0)
                    burst = $urandom_range(2, 2 * eff_cols());
                repeat (burst) begin
                    send_word(w);
                    advance_frame_model(w, 1'b1);
                    if (w.action <= ACT_REFRESH) sent_words++;
                    w.char_code = $urandom_range(0, 255);
                end
                // sender holds off until the bus side has caught up
                if (ph == 2 && !paused && sent_words >= PHASE_WORDS / 2) begin
                    wait_results_done();
                    paused = 1'b1;
                end
            end
        end

        wait_results_done();
        if (pending_bus_words.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                pending_bus_words.size()));
        if (err_count == 0) begin
            $display("tb_char_lcd_frame_buffer_refresh_core passed");
        end else begin
            $display("tb_char_lcd_frame_buffer_refresh_core failed");
        end
        $finish;
    end

endmodule
